/* rtl/svm_pkg.sv */
// ============================================================================
// svm_pkg: shared types and constants of the sample voice mixer
// Item kinds, controller states, command and status bundles, LCG constants.
// ============================================================================
package svm_pkg;

   localparam int VOICE_COUNT_DEF  = 16;
   localparam int SOUND_COUNT_DEF  = 3;
   localparam int SAMPLE_DEPTH_DEF = 4096;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_PLAY = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] REG_VOLUME = 2'd0;
   localparam logic [1:0] REG_LEN0   = 2'd1;
   localparam logic [1:0] REG_LEN1   = 2'd2;
   localparam logic [1:0] REG_LEN2   = 2'd3;

   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam logic [31:0] RNG_SEED = 32'h9E3779B9;
   localparam logic [15:0] VOLUME_MAX   = 16'd32768;
   localparam logic [15:0] STEP_RESET   = 16'd4096;
   localparam logic [15:0] GAIN_RESET   = 16'd16384;
   localparam logic [15:0] PITCH_BASE   = 16'd3686;
   localparam logic [9:0]  PITCH_SPREAD = 10'd819;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RNG_MUL,
      ST_RNG_SCALE,
      ST_CLAIM,
      ST_PLAY_DONE,
      ST_VOICE_READ,
      ST_VOICE_WAIT,
      ST_VOICE_MUL1,
      ST_VOICE_MUL2,
      ST_VOICE_ACC,
      ST_FRAME_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_write;
      logic latch_item;
      logic rng_mul;
      logic rng_scale;
      logic claim;
      logic frame_clear;
      logic voice_read;
      logic voice_mul1;
      logic voice_mul2;
      logic voice_acc;
      logic voice_next;
      logic frame_report;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic varied;
      logic voice_live;
      logic last_voice;
   } status_type;

endpackage

/* rtl/svm_ram.sv */
// ============================================================================
// svm_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ============================================================================
module svm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_ff <= mem_ff[address];
   end

   assign read_data = read_ff;
endmodule

/* rtl/svm_ctrl.sv */
// ============================================================================
// svm_ctrl: controller of the sample voice mixer
// Sequences load, play and tick items over the datapath.
// ============================================================================
module svm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         kind,
   input  svm_pkg::status_type status,
   output logic               busy,
   output svm_pkg::cmd_type   cmd
);
   import svm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (kind == KIND_PLAY) begin
                  state_in = ST_RNG_MUL;
               end else if (kind == KIND_TICK) begin
                  state_in = ST_VOICE_READ;
               end
            end
         end
         ST_RNG_MUL: begin
            state_in = status.varied ? ST_RNG_SCALE : ST_CLAIM;
         end
         ST_RNG_SCALE:  state_in = ST_CLAIM;
         ST_CLAIM:      state_in = ST_PLAY_DONE;
         ST_PLAY_DONE:  state_in = ST_IDLE;
         ST_VOICE_READ: begin
            if (status.voice_live) begin
               state_in = ST_VOICE_WAIT;
            end else if (status.last_voice) begin
               state_in = ST_FRAME_DONE;
            end
         end
         ST_VOICE_WAIT: state_in = ST_VOICE_MUL1;
         ST_VOICE_MUL1: state_in = ST_VOICE_MUL2;
         ST_VOICE_MUL2: state_in = ST_VOICE_ACC;
         ST_VOICE_ACC: begin
            state_in = status.last_voice ? ST_FRAME_DONE : ST_VOICE_READ;
         end
         ST_FRAME_DONE: state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy            = 1'b0;
            cmd.latch_item  = start;
            cmd.load_write  = start && (kind == KIND_LOAD);
            cmd.frame_clear = start && (kind == KIND_TICK);
         end
         ST_RNG_MUL:    cmd.rng_mul = 1'b1;
         ST_RNG_SCALE:  cmd.rng_scale = 1'b1;
         ST_CLAIM:      cmd.claim = 1'b1;
         ST_PLAY_DONE: ;
         ST_VOICE_READ: begin
            cmd.voice_read = 1'b1;
            cmd.voice_next = !status.voice_live;
         end
         ST_VOICE_WAIT: ;
         ST_VOICE_MUL1: cmd.voice_mul1 = 1'b1;
         ST_VOICE_MUL2: cmd.voice_mul2 = 1'b1;
         ST_VOICE_ACC: begin
            cmd.voice_acc  = 1'b1;
            cmd.voice_next = 1'b1;
         end
         ST_FRAME_DONE: cmd.frame_report = 1'b1;
         default: ;
      endcase
   end
endmodule

/* rtl/svm_datapath.sv */
// ============================================================================
// svm_datapath: voice state, sample memory, LCG and mixing accumulator
// Executes the controller's commands one step at a time.
// ============================================================================
module svm_datapath #(
   parameter int VOICE_COUNT  = svm_pkg::VOICE_COUNT_DEF,
   parameter int SOUND_COUNT  = svm_pkg::SOUND_COUNT_DEF,
   parameter int SAMPLE_DEPTH = svm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  svm_pkg::cmd_type   cmd,
   output svm_pkg::status_type status,
   input  logic [1:0]         req_sound_id,
   input  logic [11:0]        req_sample_address,
   input  logic signed [15:0] req_sample_value,
   input  logic [15:0]        req_voice_gain,
   input  logic [15:0]        req_pitch_step,
   input  logic               req_varied_pitch,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   output logic               rsp_strobe,
   output logic               rsp_result_kind,
   output logic signed [15:0] rsp_mixed_sample,
   output logic               rsp_play_accepted,
   output logic               rsp_clipped
);
   import svm_pkg::*;

   localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int MEM_DEPTH = 4 * SAMPLE_DEPTH;
   localparam int MW = $clog2(MEM_DEPTH);
   localparam logic [24:0] POS_MAX = 25'h1FFFFFF;

   // Configuration registers.
   logic [15:0] volume_ff;
   logic [12:0] len_ff [3];
   logic [12:0] csr_len;

   assign csr_len = (csr_write_data[12:0] > 13'(SAMPLE_DEPTH)) ?
                    13'(SAMPLE_DEPTH) : csr_write_data[12:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_MAX;
         len_ff[0] <= '0;
         len_ff[1] <= '0;
         len_ff[2] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_VOLUME: volume_ff <= (csr_write_data > VOLUME_MAX) ? VOLUME_MAX
                                                                    : csr_write_data;
            REG_LEN0: len_ff[0] <= csr_len;
            REG_LEN1: len_ff[1] <= csr_len;
            REG_LEN2: len_ff[2] <= csr_len;
         endcase
      end
   end

   // Latched request word.
   logic [1:0]  snd_ff;
   logic [15:0] gain_req_ff, step_req_ff;
   logic        varied_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         snd_ff      <= req_sound_id;
         gain_req_ff <= req_voice_gain;
         step_req_ff <= req_pitch_step;
         varied_ff   <= req_varied_pitch;
      end
   end

   // Pitch LCG: one multiply per step, registered between them.
   logic [31:0] rng_ff;
   logic [41:0] scaled_ff;
   logic [15:0] new_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_ff <= RNG_SEED;
      end else if (cmd.rng_mul && varied_ff) begin
         rng_ff <= rng_ff * LCG_MUL + LCG_ADD;
      end
      if (cmd.rng_scale) begin
         scaled_ff <= 42'(rng_ff[31:8]) * 42'(PITCH_SPREAD);
      end
   end

   assign new_step = varied_ff ? PITCH_BASE + {2'b0, scaled_ff[37:24]} : step_req_ff;

   // Voice state.
   logic [VOICE_COUNT-1:0] active_ff;
   logic [1:0]  vsound_ff [VOICE_COUNT];
   logic [24:0] vpos_ff   [VOICE_COUNT];
   logic [15:0] vstep_ff  [VOICE_COUNT];
   logic [15:0] vgain_ff  [VOICE_COUNT];

   // Lowest free voice.
   logic          free_found;
   logic [VW-1:0] free_idx;
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VW'(i);
         end
      end
   end

   logic claim_ok;
   assign claim_ok = free_found && (32'(snd_ff) < 32'(SOUND_COUNT));

   // Tick walk.
   logic [VW-1:0]  vi_ff;
   logic [1:0]     cur_sound;
   logic [24:0]    cur_pos;
   logic [12:0]    cur_len;
   logic [12:0]    cur_idx;
   logic           cur_live;

   assign cur_sound = vsound_ff[vi_ff];
   assign cur_pos   = vpos_ff[vi_ff];
   assign cur_idx   = cur_pos[24:12];
   assign cur_len   = (32'(cur_sound) < 32'(SOUND_COUNT) && cur_sound != 2'd3) ?
                      len_ff[cur_sound] : 13'd0;
   assign cur_live  = active_ff[vi_ff] && (cur_idx < cur_len);

   assign status.varied     = varied_ff;
   assign status.voice_live = cur_live;
   assign status.last_voice = (32'(vi_ff) == VOICE_COUNT - 1);

   logic [25:0] pos_sum;
   assign pos_sum = {1'b0, cur_pos} + 26'(vstep_ff[vi_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < VOICE_COUNT; i++) begin
            vsound_ff[i] <= '0;
            vpos_ff[i]   <= '0;
            vstep_ff[i]  <= STEP_RESET;
            vgain_ff[i]  <= GAIN_RESET;
         end
      end else begin
         if (cmd.claim && claim_ok) begin
            active_ff[free_idx] <= 1'b1;
            vsound_ff[free_idx] <= snd_ff;
            vpos_ff[free_idx]   <= '0;
            vstep_ff[free_idx]  <= new_step;
            vgain_ff[free_idx]  <= gain_req_ff;
         end
         if (cmd.voice_read && !cur_live) begin
            active_ff[vi_ff] <= 1'b0;
         end
         if (cmd.voice_acc) begin
            vpos_ff[vi_ff] <= pos_sum[25] ? POS_MAX : pos_sum[24:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_clear) begin
         vi_ff <= '0;
      end else if (cmd.voice_next && !status.last_voice) begin
         vi_ff <= vi_ff + VW'(1);
      end
   end

   // Sample memory: four banks of SAMPLE_DEPTH words, sound in the top bits.
   logic          mem_we;
   logic [MW-1:0] mem_addr;
   logic [15:0]   mem_rdata;

   assign mem_we = cmd.load_write && (32'(req_sound_id) < 32'(SOUND_COUNT)) &&
                   (32'(req_sample_address) < SAMPLE_DEPTH);
   assign mem_addr = cmd.load_write ? {req_sound_id, req_sample_address[AW-1:0]}
                                    : {cur_sound, cur_idx[AW-1:0]};

   svm_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_sample_ram (
      .clock       (clock),
      .write_enable(mem_we),
      .address     (mem_addr),
      .write_data  (req_sample_value),
      .read_data   (mem_rdata)
   );

   // Mixing: sample*gain, then *volume, each product registered.
   logic signed [32:0] prod1_ff;
   logic signed [49:0] prod2_ff;
   logic signed [53:0] acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.voice_mul1) begin
         prod1_ff <= $signed(mem_rdata) * $signed({1'b0, vgain_ff[vi_ff]});
      end
      if (cmd.voice_mul2) begin
         prod2_ff <= prod1_ff * $signed({1'b0, volume_ff});
      end
      if (cmd.frame_clear) begin
         acc_ff <= 54'sd268435456;
      end else if (cmd.voice_acc) begin
         acc_ff <= acc_ff + 54'(prod2_ff);
      end
   end

   logic signed [24:0] q;
   logic               q_hi, q_lo;
   assign q    = acc_ff[53:29];
   assign q_hi = q > 25'sd32767;
   assign q_lo = q < -25'sd32768;

   // Result register.
   logic        strobe_ff, kind_ff, acc_ok_ff, clip_ff;
   logic [15:0] mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.claim || cmd.frame_report;
      end
      if (cmd.claim) begin
         kind_ff   <= 1'b1;
         mix_ff    <= '0;
         acc_ok_ff <= claim_ok;
         clip_ff   <= 1'b0;
      end else if (cmd.frame_report) begin
         kind_ff   <= 1'b0;
         mix_ff    <= q_hi ? 16'h7FFF : (q_lo ? 16'h8000 : q[15:0]);
         acc_ok_ff <= 1'b0;
         clip_ff   <= q_hi || q_lo;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_mixed_sample  = mix_ff;
   assign rsp_play_accepted = acc_ok_ff;
   assign rsp_clipped       = clip_ff;
endmodule

/* rtl/sample_voice_mixer.sv */
// ============================================================================
// sample_voice_mixer: wavetable sample playback with a voice mixer
// Top level joining the controller and the datapath.
// ============================================================================
// A word is offered on the req_ ports with start; it is taken at a clock edge
// where start is high and busy is low. Kind load writes one sample into the
// sample RAM and gives no result. Kind play claims the lowest free voice and
// returns one report word. Kind tick walks all voices and returns one frame.
// Results appear on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe; the receiver cannot stall them.
// Sequencing: a load is taken in the idle state. A play passes the LCG step,
// then the scaling step with varied pitch only, the claim and a done state;
// its report is registered from the claim. A tick visits every voice in turn;
// live voices pass the single shared multiply chain, one sample RAM word each.
// Reset restores the master volume, clears the lengths, frees all voices and
// reseeds the LCG. Sample RAM contents are undefined until written.
// The csr_ port writes registers only while busy is low: a rule for the user; the block does not enforce it.
// ============================================================================
module sample_voice_mixer #(
   parameter int VOICE_COUNT  = svm_pkg::VOICE_COUNT_DEF,
   parameter int SOUND_COUNT  = svm_pkg::SOUND_COUNT_DEF,
   parameter int SAMPLE_DEPTH = svm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [1:0]         req_sound_id,
   input  logic [11:0]        req_sample_address,
   input  logic signed [15:0] req_sample_value,
   input  logic [15:0]        req_voice_gain,
   input  logic [15:0]        req_pitch_step,
   input  logic               req_varied_pitch,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   output logic               rsp_strobe,
   output logic               rsp_result_kind,
   output logic signed [15:0] rsp_mixed_sample,
   output logic               rsp_play_accepted,
   output logic               rsp_clipped
);
   import svm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller owns sequencing; the datapath owns all data state.
   svm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_kind),
      .status(status),
      .busy  (busy),
      .cmd   (cmd)
   );

   svm_datapath #(
      .VOICE_COUNT (VOICE_COUNT),
      .SOUND_COUNT (SOUND_COUNT),
      .SAMPLE_DEPTH(SAMPLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sound_id      (req_sound_id),
      .req_sample_address(req_sample_address),
      .req_sample_value  (req_sample_value),
      .req_voice_gain    (req_voice_gain),
      .req_pitch_step    (req_pitch_step),
      .req_varied_pitch  (req_varied_pitch),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_mixed_sample  (rsp_mixed_sample),
      .rsp_play_accepted (rsp_play_accepted),
      .rsp_clipped       (rsp_clipped)
   );
endmodule
